// File: rtl/frc_pkg.sv
// Shared constants, side-band struct and component alignment for the
// Fresnel reflectance pipeline. No dependencies.
package frc_pkg;

  localparam int COMP_W      = 16;
  localparam int IDX_W       = 16;
  localparam int AC_W        = 33;
  localparam int TDATA_W     = ((8 * COMP_W + IDX_W + 7) / 8) * 8;

  localparam int RAD_W       = 58;
  localparam int SQ_REM_W    = 31;
  localparam int ROOT_W      = 29;
  localparam int SQ_STEPS    = 29;

  localparam int DIV_W       = 50;
  localparam int QUO_W       = 31;
  localparam int FEED_W      = 31;
  localparam int SINT_STEPS  = 28;
  localparam int RATIO_STEPS = 30;

  localparam logic [IDX_W-1:0] ONE_Q12 = 16'd4096;
  localparam logic [16:0]      ONE_Q15 = 17'd32768;
  localparam logic [56:0]      ONE_Q56 = 57'h100_0000_0000_0000;
  localparam logic [62:0]      HALF_Q46 = 63'h0000_2000_0000_0000;

  typedef struct packed {
    logic             tir;
    logic             zero;
    logic [IDX_W-1:0] etai;
    logic [IDX_W-1:0] etat;
    logic [AC_W-1:0]  ac;
  } side_t;

  function automatic logic signed [15:0] comp_q14(input logic [COMP_W-1:0] raw);
    logic [31:0] w;
    w = 32'(raw) << (32 - COMP_W);
    return w[31:16];
  endfunction

endpackage

// File: rtl/frc_sqrt_cell.sv
// One restoring square-root step: two radicand bits in, one root bit out.
// Depends on frc_pkg.
module frc_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic [frc_pkg::RAD_W-1:0]    rad_i,
  input  logic [frc_pkg::SQ_REM_W-1:0] rem_i,
  input  logic [frc_pkg::ROOT_W-1:0]   root_i,
  input  frc_pkg::side_t               side_i,
  output logic                         vld_o,
  output logic [frc_pkg::RAD_W-1:0]    rad_o,
  output logic [frc_pkg::SQ_REM_W-1:0] rem_o,
  output logic [frc_pkg::ROOT_W-1:0]   root_o,
  output frc_pkg::side_t               side_o
);
  import frc_pkg::*;

  logic                  vld_r;
  logic [RAD_W-1:0]      rad_r, rad_nxt;
  logic [SQ_REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  side_t                 side_r;
  logic [SQ_REM_W+1:0]   rem2, trial, diff;
  logic                  ge;

  always_comb begin
    rem2     = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial    = (SQ_REM_W+2)'({root_i, 2'b01});
    ge       = rem2 >= trial;
    diff     = rem2 - trial;
    rem_nxt  = ge ? diff[SQ_REM_W-1:0] : rem2[SQ_REM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// File: rtl/frc_div_cell.sv
// One restoring division step: one dividend bit in, one quotient bit out.
// Depends on frc_pkg.
module frc_div_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [frc_pkg::DIV_W-1:0]  rem_i,
  input  logic [frc_pkg::DIV_W-1:0]  den_i,
  input  logic [frc_pkg::FEED_W-1:0] feed_i,
  input  logic [frc_pkg::QUO_W-1:0]  quo_i,
  input  frc_pkg::side_t             side_i,
  output logic                       vld_o,
  output logic [frc_pkg::DIV_W-1:0]  rem_o,
  output logic [frc_pkg::DIV_W-1:0]  den_o,
  output logic [frc_pkg::FEED_W-1:0] feed_o,
  output logic [frc_pkg::QUO_W-1:0]  quo_o,
  output frc_pkg::side_t             side_o
);
  import frc_pkg::*;

  logic               vld_r;
  logic [DIV_W-1:0]   rem_r, rem_nxt, den_r;
  logic [FEED_W-1:0]  feed_r, feed_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  side_t              side_r;
  logic [DIV_W:0]     rem2, diff;
  logic               ge;

  always_comb begin
    rem2     = {rem_i, feed_i[FEED_W-1]};
    ge       = rem2 >= {1'b0, den_i};
    diff     = rem2 - {1'b0, den_i};
    rem_nxt  = ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
    quo_nxt  = {quo_i[QUO_W-2:0], ge};
    feed_nxt = {feed_i[FEED_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      feed_r <= feed_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign feed_o = feed_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

// File: rtl/fresnel_reflectance_top.sv
// Fresnel reflectance pipeline.
// Throughput one request per cycle; set by chains of square-root and divider cells,
// one bit per cell, all advancing together while the output register can move.
// Reset (rst_n low, synchronous) empties every stage and the output register.
// Depends on frc_pkg, frc_sqrt_cell and frc_div_cell.
module fresnel_reflectance_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // dir_w, dir_x, dir_y, dir_z, nrm_w, nrm_x, nrm_y, nrm_z, refr_index
  input  logic [frc_pkg::TDATA_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // reflectance
  output logic [15:0]                 out_tdata,
  // total_internal
  output logic [0:0]                  out_tuser
);
  import frc_pkg::*;

  logic en;

  logic signed [15:0] dir [4];
  logic signed [15:0] nrm [4];

  logic                s0_vld_r;
  logic signed [31:0]  s0_prod_r [4];
  logic [IDX_W-1:0]    s0_idx_r;

  logic signed [33:0]  dot;
  logic                leaving;
  logic [AC_W-1:0]     ac_abs;
  logic                s1_vld_r;
  logic [AC_W-1:0]     s1_ac_r;
  logic [IDX_W-1:0]    s1_etai_r, s1_etat_r;

  logic                s2_vld_r, s2_big_r;
  logic [55:0]         s2_sq_r;
  side_t               s2_side_r;

  logic                va [SQ_STEPS+1];
  logic [RAD_W-1:0]    rad_a [SQ_STEPS+1];
  logic [SQ_REM_W-1:0] rem_a [SQ_STEPS+1];
  logic [ROOT_W-1:0]   root_a [SQ_STEPS+1];
  side_t               side_a [SQ_STEPS+1];

  logic                s3_vld_r;
  logic [44:0]         s3_p1_r;
  side_t               s3_side_r, s3_side;

  logic                vb [SINT_STEPS+1];
  logic [DIV_W-1:0]    rem_b [SINT_STEPS+1];
  logic [DIV_W-1:0]    den_b [SINT_STEPS+1];
  logic [FEED_W-1:0]   feed_b [SINT_STEPS+1];
  logic [QUO_W-1:0]    quo_b [SINT_STEPS+1];
  side_t               side_b [SINT_STEPS+1];

  logic                s4_vld_r;
  logic [55:0]         s4_sq_r;
  side_t               s4_side_r;

  logic                vc [SQ_STEPS+1];
  logic [RAD_W-1:0]    rad_c [SQ_STEPS+1];
  logic [SQ_REM_W-1:0] rem_c [SQ_STEPS+1];
  logic [ROOT_W-1:0]   root_c [SQ_STEPS+1];
  side_t               side_c [SQ_STEPS+1];

  logic                s5_vld_r;
  logic [48:0]         s5_a_r, s5_cc_r;
  logic [44:0]         s5_b_r, s5_d_r;
  side_t               s5_side_r, s5_side;

  logic [DIV_W-1:0]    den1, den2, num1, num2;
  logic                s6_vld_r;
  logic [DIV_W-1:0]    s6_num1_r, s6_den1_r, s6_num2_r, s6_den2_r;
  side_t               s6_side_r;

  logic                g1, g2;
  logic [DIV_W-1:0]    r1, r2;
  logic                s7_vld_r, s7_g1_r, s7_g2_r;
  logic [DIV_W-1:0]    s7_rem1_r, s7_rem2_r, s7_den1_r, s7_den2_r;
  side_t               s7_side_r;

  logic                vd [RATIO_STEPS+1];
  logic [DIV_W-1:0]    rem_d [RATIO_STEPS+1];
  logic [DIV_W-1:0]    den_d [RATIO_STEPS+1];
  logic [FEED_W-1:0]   feed_d [RATIO_STEPS+1];
  logic [QUO_W-1:0]    quo_d [RATIO_STEPS+1];
  side_t               side_d [RATIO_STEPS+1];
  logic                ve [RATIO_STEPS+1];
  logic [DIV_W-1:0]    rem_e [RATIO_STEPS+1];
  logic [DIV_W-1:0]    den_e [RATIO_STEPS+1];
  logic [FEED_W-1:0]   feed_e [RATIO_STEPS+1];
  logic [QUO_W-1:0]    quo_e [RATIO_STEPS+1];
  side_t               side_e [RATIO_STEPS+1];

  logic                s8_vld_r, s8_tir_r, s8_zero_r;
  logic [61:0]         s8_rs2_r, s8_rp2_r;

  logic [62:0]         sum_sq;
  logic [16:0]         refl;
  logic                out_vld_r, out_tir_r;
  logic [15:0]         out_data_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dir[i] = comp_q14(in_tdata[i*COMP_W +: COMP_W]);
      nrm[i] = comp_q14(in_tdata[(4+i)*COMP_W +: COMP_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= va[SQ_STEPS];
      s4_vld_r <= vb[SINT_STEPS];
      s5_vld_r <= vc[SQ_STEPS];
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= vd[RATIO_STEPS];
      out_vld_r <= s8_vld_r;
    end
  end

  // dot product and index selection
  always_comb begin
    dot = 34'(s0_prod_r[0]) + 34'(s0_prod_r[1]) + 34'(s0_prod_r[2]) + 34'(s0_prod_r[3]);
    leaving = !dot[33] && (dot != 34'sd0);
    ac_abs  = dot[33] ? AC_W'(-dot) : AC_W'(dot);
  end

  // sint numerator, total internal reflection test
  always_comb begin
    s3_side     = s3_side_r;
    s3_side.tir = (s3_side_r.etat == '0) || (s3_p1_r >= {1'b0, s3_side_r.etat, 28'd0});
  end

  // amplitude ratio numerators and denominators, zero test and first quotient bits
  always_comb begin
    den1 = DIV_W'(s5_a_r) + DIV_W'(s5_b_r);
    den2 = DIV_W'(s5_cc_r) + DIV_W'(s5_d_r);
    num1 = (s5_a_r >= 49'(s5_b_r)) ? DIV_W'(s5_a_r - 49'(s5_b_r))
                                   : DIV_W'(49'(s5_b_r) - s5_a_r);
    num2 = (s5_cc_r >= 49'(s5_d_r)) ? DIV_W'(s5_cc_r - 49'(s5_d_r))
                                    : DIV_W'(49'(s5_d_r) - s5_cc_r);
    s5_side      = s5_side_r;
    s5_side.zero = (den1 == '0) || (den2 == '0);
    g1 = s6_num1_r >= s6_den1_r;
    g2 = s6_num2_r >= s6_den2_r;
    r1 = g1 ? s6_num1_r - s6_den1_r : s6_num1_r;
    r2 = g2 ? s6_num2_r - s6_den2_r : s6_num2_r;
  end

  always_comb begin
    sum_sq = 63'(s8_rs2_r) + 63'(s8_rp2_r) + HALF_Q46;
    refl   = sum_sq[62:46];
    if (refl > ONE_Q15) begin
      refl = ONE_Q15;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s0_prod_r[i] <= dir[i] * nrm[i];
      end
      s0_idx_r  <= in_tdata[8*COMP_W +: IDX_W];

      s1_ac_r   <= ac_abs;
      s1_etai_r <= leaving ? s0_idx_r : ONE_Q12;
      s1_etat_r <= leaving ? ONE_Q12 : s0_idx_r;

      s2_sq_r        <= s1_ac_r[27:0] * s1_ac_r[27:0];
      s2_big_r       <= |s1_ac_r[AC_W-1:28];
      s2_side_r.tir  <= 1'b0;
      s2_side_r.zero <= 1'b0;
      s2_side_r.etai <= s1_etai_r;
      s2_side_r.etat <= s1_etat_r;
      s2_side_r.ac   <= s1_ac_r;

      s3_p1_r   <= root_a[SQ_STEPS] * side_a[SQ_STEPS].etai;
      s3_side_r <= side_a[SQ_STEPS];

      s4_sq_r   <= quo_b[SINT_STEPS][27:0] * quo_b[SINT_STEPS][27:0];
      s4_side_r <= side_b[SINT_STEPS];

      s5_a_r    <= side_c[SQ_STEPS].etat * side_c[SQ_STEPS].ac;
      s5_cc_r   <= side_c[SQ_STEPS].etai * side_c[SQ_STEPS].ac;
      s5_b_r    <= side_c[SQ_STEPS].etai * root_c[SQ_STEPS];
      s5_d_r    <= side_c[SQ_STEPS].etat * root_c[SQ_STEPS];
      s5_side_r <= side_c[SQ_STEPS];

      s6_num1_r <= num1;
      s6_den1_r <= den1;
      s6_num2_r <= num2;
      s6_den2_r <= den2;
      s6_side_r <= s5_side;

      s7_g1_r   <= g1;
      s7_g2_r   <= g2;
      s7_rem1_r <= r1;
      s7_rem2_r <= r2;
      s7_den1_r <= s6_den1_r;
      s7_den2_r <= s6_den2_r;
      s7_side_r <= s6_side_r;

      s8_rs2_r  <= quo_d[RATIO_STEPS] * quo_d[RATIO_STEPS];
      s8_rp2_r  <= quo_e[RATIO_STEPS] * quo_e[RATIO_STEPS];
      s8_tir_r  <= side_d[RATIO_STEPS].tir;
      s8_zero_r <= side_e[RATIO_STEPS].zero;

      out_tir_r  <= s8_tir_r;
      out_data_r <= (s8_tir_r || s8_zero_r) ? ONE_Q15[15:0] : refl[15:0];
    end
  end

  // sin of incidence
  assign va[0]     = s2_vld_r;
  assign rad_a[0]  = s2_big_r ? '0 : {1'b0, ONE_Q56 - {1'b0, s2_sq_r}};
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign side_a[0] = s2_side_r;

  // sint = sini * etai / etat
  assign vb[0]     = s3_vld_r;
  assign rem_b[0]  = DIV_W'(s3_p1_r[44:28]);
  assign den_b[0]  = DIV_W'(s3_side_r.etat);
  assign feed_b[0] = {s3_p1_r[27:0], 3'b000};
  assign quo_b[0]  = '0;
  assign side_b[0] = s3_side;

  // cos of transmission
  assign vc[0]     = s4_vld_r;
  assign rad_c[0]  = {1'b0, ONE_Q56 - {1'b0, s4_sq_r}};
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign side_c[0] = s4_side_r;

  // s and p ratios
  assign vd[0]     = s7_vld_r;
  assign rem_d[0]  = s7_rem1_r;
  assign den_d[0]  = s7_den1_r;
  assign feed_d[0] = '0;
  assign quo_d[0]  = QUO_W'(s7_g1_r);
  assign side_d[0] = s7_side_r;
  assign ve[0]     = s7_vld_r;
  assign rem_e[0]  = s7_rem2_r;
  assign den_e[0]  = s7_den2_r;
  assign feed_e[0] = '0;
  assign quo_e[0]  = QUO_W'(s7_g2_r);
  assign side_e[0] = s7_side_r;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqa
    frc_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(va[k]), .rad_i(rad_a[k]), .rem_i(rem_a[k]), .root_i(root_a[k]),
      .side_i(side_a[k]),
      .vld_o(va[k+1]), .rad_o(rad_a[k+1]), .rem_o(rem_a[k+1]), .root_o(root_a[k+1]),
      .side_o(side_a[k+1])
    );
  end

  for (genvar k = 0; k < SINT_STEPS; k++) begin : g_divb
    frc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vb[k]), .rem_i(rem_b[k]), .den_i(den_b[k]), .feed_i(feed_b[k]),
      .quo_i(quo_b[k]), .side_i(side_b[k]),
      .vld_o(vb[k+1]), .rem_o(rem_b[k+1]), .den_o(den_b[k+1]), .feed_o(feed_b[k+1]),
      .quo_o(quo_b[k+1]), .side_o(side_b[k+1])
    );
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqc
    frc_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vc[k]), .rad_i(rad_c[k]), .rem_i(rem_c[k]), .root_i(root_c[k]),
      .side_i(side_c[k]),
      .vld_o(vc[k+1]), .rad_o(rad_c[k+1]), .rem_o(rem_c[k+1]), .root_o(root_c[k+1]),
      .side_o(side_c[k+1])
    );
  end

  for (genvar k = 0; k < RATIO_STEPS; k++) begin : g_divd
    frc_div_cell u_cell_s (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vd[k]), .rem_i(rem_d[k]), .den_i(den_d[k]), .feed_i(feed_d[k]),
      .quo_i(quo_d[k]), .side_i(side_d[k]),
      .vld_o(vd[k+1]), .rem_o(rem_d[k+1]), .den_o(den_d[k+1]), .feed_o(feed_d[k+1]),
      .quo_o(quo_d[k+1]), .side_o(side_d[k+1])
    );
    frc_div_cell u_cell_p (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(ve[k]), .rem_i(rem_e[k]), .den_i(den_e[k]), .feed_i(feed_e[k]),
      .quo_i(quo_e[k]), .side_i(side_e[k]),
      .vld_o(ve[k+1]), .rem_o(rem_e[k+1]), .den_o(den_e[k+1]), .feed_o(feed_e[k+1]),
      .quo_o(quo_e[k+1]), .side_o(side_e[k+1])
    );
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_tir_r;

  a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == ONE_Q15[15:0])
    else $error("total internal reflection without full reflectance");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= ONE_Q15[15:0])
    else $error("reflectance above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s0_vld_r) && $stable(s8_vld_r) && $stable(vd[RATIO_STEPS]))
    else $error("pipeline moved during stall");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    vd[RATIO_STEPS] == ve[RATIO_STEPS])
    else $error("ratio lanes out of step");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

// File: dv/fresnel_reflectance_chk.sv
// Checker for the Fresnel reflectance pipeline: watches both stream channels,
// predicts reflectance and total-internal flag per request, and counts mismatches.
// Depends on frc_pkg for the packed input width.
module fresnel_reflectance_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [frc_pkg::TDATA_W-1:0] in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [15:0]                 out_tdata,
  input  logic [0:0]                  out_tuser,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic [15:0] refl;
    logic        tir;
  } fresnel_res_t;

  fresnel_res_t refl_queue[$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] amp_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, r;
    q = 0;
    r = num;
    if (r >= den) begin
      q = 1;
      r = r - den;
    end
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mag_diff(input logic [63:0] a, input logic [63:0] b);
    return a >= b ? a - b : b - a;
  endfunction

  function automatic fresnel_res_t predict_reflectance(input logic [frc_pkg::TDATA_W-1:0] d);
    longint cosi;
    logic [63:0] idx, etai, etat, ac, sini, sint, cost, a, b, cc, dd, rs, rp, sum;
    fresnel_res_t res;
    cosi = 0;
    for (int i = 0; i < 4; i++)
      cosi += longint'($signed(d[16*i +: 16])) * longint'($signed(d[16*(i+4) +: 16]));
    idx = 64'(d[128 +: 16]);
    etai = cosi > 0 ? idx : 64'd4096;
    etat = cosi > 0 ? 64'd4096 : idx;
    ac = cosi < 0 ? 64'(-cosi) : 64'(cosi);
    sini = ac >= (64'd1 << 28) ? 64'd0 : floor_sqrt((64'd1 << 56) - ac * ac);
    res.tir = 1'b0;
    if (etat == 0 || sini * etai >= (etat << 28)) begin
      res.refl = 16'd32768;
      res.tir = 1'b1;
      return res;
    end
    sint = (sini * etai) / etat;
    cost = floor_sqrt((64'd1 << 56) - sint * sint);
    a = etat * ac;
    b = etai * cost;
    cc = etai * ac;
    dd = etat * cost;
    if (a + b == 0 || cc + dd == 0) begin
      res.refl = 16'd32768;
    end else begin
      rs = amp_ratio(mag_diff(a, b), a + b);
      rp = amp_ratio(mag_diff(cc, dd), cc + dd);
      sum = rs * rs + rp * rp;
      sum = (sum + (64'd1 << 45)) >> 46;
      res.refl = sum > 32768 ? 16'd32768 : sum[15:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    fresnel_res_t exp_res;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      pending <= 0;
      refl_queue.delete();
    end else begin
      if (in_tvalid && in_tready) refl_queue.push_back(predict_reflectance(in_tdata));
      if (out_tvalid && out_tready) begin
        if (refl_queue.size() == 0) begin
          $error("unexpected result reflectance=%0d", out_tdata);
          errs++;
        end else begin
          exp_res = refl_queue.pop_front();
          if (out_tdata !== exp_res.refl) begin
            $error("reflectance expected %0d actual %0d", exp_res.refl, out_tdata);
            errs++;
          end
          if (out_tuser[0] !== exp_res.tir) begin
            $error("total_internal expected %0d actual %0d", exp_res.tir, out_tuser[0]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= refl_queue.size();
    end
  end

endmodule

// File: dv/fresnel_reflectance_top_tb.sv
// Stimulus and verdict for the Fresnel reflectance pipeline: directed requests, then random
// requests under four idling phases. Depends on frc_pkg, the RTL and the checker.
module fresnel_reflectance_top_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [frc_pkg::TDATA_W-1:0] in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [15:0]                 out_tdata;
  logic [0:0]                  out_tuser;
  int                          fail_count;
  int                          pending;
  int                          idle_cycles;
  int                          send_idle_pct;
  int                          recv_stall_pct;

  always #5 clk = ~clk;

  fresnel_reflectance_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  fresnel_reflectance_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(32768)) - 16384);
      3: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [frc_pkg::TDATA_W-1:0] pack_request(
    input logic [15:0] dw, dx, dy, dz, nw, nx, ny, nz, idx);
    logic [frc_pkg::TDATA_W-1:0] d;
    d = '0;
    d[143:0] = {idx, nz, ny, nx, nw, dz, dy, dx, dw};
    return d;
  endfunction

  function automatic logic [frc_pkg::TDATA_W-1:0] rand_request();
    logic [15:0] c[8];
    logic [15:0] idx;
    real th, ph, pn;
    if ($urandom_range(3) == 0) begin
      foreach (c[i]) c[i] = rand_comp();
    end else begin
      // near-unit ray and normal at a random angle
      th = $urandom_range(62831) / 10000.0;
      ph = $urandom_range(62831) / 10000.0;
      pn = $urandom_range(1) ? 1.0 : -1.0;
      c = '{16'($rtoi(16384.0 * $cos(th))), 16'($rtoi(16384.0 * $sin(th))), 16'd0, 16'd0,
            16'($rtoi(16384.0 * pn * $cos(ph))), 16'($rtoi(16384.0 * pn * $sin(ph))),
            16'd0, 16'd0};
      if ($urandom_range(3) == 0) begin
        c[2] = 16'($urandom_range(255));
        c[7] = 16'($urandom_range(255));
      end
    end
    case ($urandom_range(5))
      0: idx = 16'($urandom);
      1: idx = 16'($urandom_range(4095));
      default: idx = 16'($urandom_range(12288, 4096));
    endcase
    return pack_request(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], idx);
  endfunction

  task automatic send_request(input logic [frc_pkg::TDATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [frc_pkg::TDATA_W-1:0] directed[$];
    int phase_pct[4][2];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase_pct = '{'{0, 0}, '{57, 0}, '{0, 57}, '{16, 16}};
    directed = '{
      pack_request(16'h4000, 0, 0, 0, 16'hc000, 0, 0, 0, 16'd6144),
      pack_request(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'd6144),
      pack_request(16'h2d41, 16'h2d41, 0, 0, 16'h4000, 0, 0, 0, 16'd6144),
      pack_request(16'h3f00, 16'h0b00, 0, 0, 16'h4000, 0, 0, 0, 16'd6144),
      pack_request(16'h2d41, 16'h2d41, 0, 0, 16'hc000, 0, 0, 0, 16'd0),
      pack_request(16'h2d41, 16'h2d41, 0, 0, 16'h4000, 0, 0, 0, 16'd0),
      pack_request(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'd0),
      pack_request(0, 16'h4000, 0, 0, 16'h4000, 0, 0, 0, 16'd6144),
      pack_request(0, 16'h4000, 0, 0, 16'h4000, 0, 0, 0, 16'd0),
      pack_request(0, 0, 0, 0, 0, 0, 0, 0, 16'd4096),
      pack_request(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff),
      pack_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                   16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff),
      pack_request(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                   16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'd4096),
      pack_request(16'hffff, 16'h0001, 16'haaaa, 16'h5555,
                   16'h5555, 16'haaaa, 16'h0001, 16'hffff, 16'h8001),
      pack_request(16'h1000, 0, 16'h1000, 0, 0, 16'h1000, 0, 16'h1000, 16'd4096),
      pack_request(16'h4000, 0, 0, 0, 16'hc000, 0, 0, 0, 16'd4096)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_request(directed[i]);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int n = 0; n < 200; n++) send_request(rand_request());
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
